/* sv/lkvc_pkg.sv */
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int EC_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] store_value;
	} cmd_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} match_t;

	typedef logic [ENTRIES-1:0][KEY_W-1:0] key_array_t;

endpackage

/* sv/lkvc_match.sv */
module lkvc_match (
	input  lkvc_pkg::key_array_t                keys,
	input  logic [lkvc_pkg::ENTRIES-1:0]        valid,
	input  logic [lkvc_pkg::KEY_W-1:0]          key,
	output lkvc_pkg::match_t                    match
);
	import lkvc_pkg::*;

	// parallel compare, lowest slot wins
	always_comb begin
		match = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && (keys[i] == key)) begin
				match.hit   = 1'b1;
				match.index = IDX_W'(i);
			end
		end
	end

endmodule

/* sv/lru_key_value_cache.sv */
// channel   | signals                        | direction | transfer
// ----------+--------------------------------+-----------+------------------------------
// command   | start, busy, command           | in        | edge with start high, busy low
// result    | done, result                   | out       | one cycle per strobe on done
// capacity  | cfg_valid, cfg_ready, cfg_data | in        | edge with cfg_valid and cfg_ready
//
// one item per cycle; busy never rises
// a get raises done at the next edge after the one that took it, for one cycle; a put gives none
// all work is one pass of key compare and rank update between the input and result registers
// arst_n clears the valid bits, occupancy, pipeline strobes and sets capacity to 16
// the receiver cannot stall: every result is on the port for exactly one cycle
module lru_key_value_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lkvc_pkg::cmd_t                command,
	output logic                          done,
	output lkvc_pkg::rsp_t                result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data
);
	import lkvc_pkg::*;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic [CAP_W-1:0]       cap_q;
	key_array_t             keys_q;
	logic [VAL_W-1:0]       values_q [ENTRIES];
	logic [RANK_W-1:0]      rank_q   [ENTRIES];
	logic [ENTRIES-1:0]     valid_q;
	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	match_t                 match;
	logic [EC_W-1:0]        eff_cap;
	logic [EC_W-1:0]        cnt_ext;
	logic                   need_evict;
	logic [ENTRIES-1:0]     valid_kept;
	logic [IDX_W-1:0]       free_idx;
	logic [RANK_W-1:0]      hit_rank;
	logic                   is_put;
	logic                   touch;
	logic                   insert;
	logic [RANK_W-1:0]      rank_d   [ENTRIES];
	logic [ENTRIES-1:0]     valid_d;
	logic [CNT_W-1:0]       count_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = rsp_q;

	lkvc_match u_match (
		.keys  (keys_q),
		.valid (valid_q),
		.key   (cmd_s1.lookup_key),
		.match (match)
	);

	assign is_put   = (cmd_s1.operation == OP_PUT);
	assign touch    = valid_s1 && match.hit;
	assign insert   = valid_s1 && is_put && !match.hit;
	assign hit_rank = rank_q[match.index];

	always_comb begin
		eff_cap = EC_W'(cap_q);
		if (eff_cap == '0) begin
			eff_cap = EC_W'(1);
		end
		if (eff_cap > EC_W'(ENTRIES)) begin
			eff_cap = EC_W'(ENTRIES);
		end
	end

	assign cnt_ext    = EC_W'(count_q);
	assign need_evict = (cnt_ext >= eff_cap);

	// when occupancy has reached capacity, drop every entry whose rank is at or past the new tail
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_kept[i] = valid_q[i] &&
				!(need_evict && (EC_W'(rank_q[i]) >= (eff_cap - EC_W'(1))));
		end
	end

	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_kept[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		valid_d = valid_q;
		count_d = count_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (touch) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == match.index) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
		end else if (insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == free_idx) begin
					rank_d[i] = '0;
				end else if (valid_kept[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
			valid_d = valid_kept;
			valid_d[free_idx] = 1'b1;
			count_d = need_evict ? CNT_W'(eff_cap) : (count_q + CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			valid_q  <= '0;
			count_q  <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1 && !is_put;
			valid_q  <= valid_d;
			count_q  <= count_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= command;
		end
		rsp_q.hit        <= match.hit;
		rsp_q.read_value <= match.hit ? values_q[match.index] : MISS_VALUE;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_q[i] <= rank_d[i];
		end
		if (touch && is_put) begin
			values_q[match.index] <= cmd_s1.store_value;
		end else if (insert) begin
			values_q[free_idx] <= cmd_s1.store_value;
			keys_q[free_idx]   <= cmd_s1.lookup_key;
		end
	end

endmodule

/* tb/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 104;
	localparam int POOL_MAX   = 24;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             command;
	logic             done;
	rsp_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the cache
	logic [KEY_W-1:0] m_key [ENTRIES];
	logic [VAL_W-1:0] m_val [ENTRIES];
	bit               m_valid [ENTRIES];
	int unsigned      m_rank [ENTRIES];
	int unsigned      m_count;
	logic [CAP_W-1:0] m_cap;

	cmd_t pend_q[$];
	rsp_t expected_reads[$];

	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int               pool_n;
	int               gap_odds;
	int               gap_left;
	logic             start_next;
	logic             cmd_taken;
	rsp_t             got_read;

	int err_count;
	int n_gets;
	int n_hits;
	int n_puts;
	int n_cfg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("lru_key_value_cache regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic promote_entry(input int s);
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			if (m_valid[i] && m_rank[i] < m_rank[s])
				m_rank[i]++;
		end
		m_rank[s] = 0;
	endtask

	task automatic cache_apply(input cmd_t c);
		int   i;
		int   slot;
		int   victim;
		int   cap;
		rsp_t rd;
		slot = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot < 0 && m_valid[i] && m_key[i] == c.lookup_key)
				slot = i;
		end
		if (c.operation == OP_GET) begin
			n_gets++;
			if (slot >= 0) begin
				promote_entry(slot);
				rd.hit = 1'b1;
				rd.read_value = m_val[slot];
				n_hits++;
			end else begin
				rd.hit = 1'b0;
				rd.read_value = MISS_VALUE;
			end
			expected_reads.push_back(rd);
		end else if (slot >= 0) begin
			n_puts++;
			m_val[slot] = c.store_value;
			promote_entry(slot);
		end else begin
			n_puts++;
			cap = (m_cap == 0) ? 1 : (m_cap > ENTRIES) ? ENTRIES : int'(m_cap);
			while (m_count >= cap && m_count > 0) begin
				victim = -1;
				for (i = 0; i < ENTRIES; i++) begin
					if (victim < 0 && m_valid[i] && m_rank[i] == m_count - 1)
						victim = i;
				end
				if (victim < 0)
					break;
				m_valid[victim] = 1'b0;
				m_count--;
			end
			slot = -1;
			for (i = 0; i < ENTRIES; i++) begin
				if (!m_valid[i]) begin
					if (slot < 0)
						slot = i;
				end else begin
					m_rank[i]++;
				end
			end
			if (slot >= 0) begin
				m_key[slot] = c.lookup_key;
				m_val[slot] = c.store_value;
				m_valid[slot] = 1'b1;
				m_rank[slot] = 0;
				m_count++;
			end
		end
	endtask

	// result check, then the item taken at this edge, then the capacity write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_taken = 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				m_valid[i] = 1'b0;
				m_rank[i] = 0;
			end
			m_count = 0;
			m_cap = CAP_RESET;
		end else begin
			if (done) begin
				if (expected_reads.size() == 0) begin
					flag_mismatch($sformatf("result with none pending: hit=%0b value=%h",
						result.hit, result.read_value));
				end else begin
					got_read = expected_reads.pop_front();
					if (result.hit !== got_read.hit)
						flag_mismatch($sformatf("hit %b, want %b", result.hit, got_read.hit));
					if (result.read_value !== got_read.read_value)
						flag_mismatch($sformatf("read_value %h, want %h",
							result.read_value, got_read.read_value));
				end
			end
			cmd_taken = start && !busy;
			if (cmd_taken)
				cache_apply(command);
			if (cfg_valid && cfg_ready) begin
				m_cap = cfg_data;
				n_cfg++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			start_next = start && !cmd_taken;
			if (!start_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() > 0) begin
					command = pend_q.pop_front();
					start_next = 1'b1;
					if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0)
						gap_left = $urandom_range(1, 11);
				end
			end
			start = start_next;
		end
	end

	function automatic cmd_t mk_cmd(input op_t op, input logic [31:0] k, input logic [31:0] v);
		cmd_t c;
		c.operation = op;
		c.lookup_key = k;
		c.store_value = v;
		return c;
	endfunction

	task automatic wait_quiet();
		do begin
			@(posedge clk);
			#1;
		end while (pend_q.size() != 0 || (start && !cmd_taken) || expected_reads.size() != 0);
		// a put can still be in flight with nothing pending
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_quiet();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic fill_pool();
		int i;
		pool_n = $urandom_range(1, POOL_MAX);
		for (i = 0; i < POOL_MAX; i++) begin
			case ($urandom_range(0, 19))
				0:       key_pool[i] = 32'h0000_0000;
				1:       key_pool[i] = 32'hffff_ffff;
				2:       key_pool[i] = 32'h7fff_ffff;
				3:       key_pool[i] = 32'h8000_0000;
				default: key_pool[i] = $urandom;
			endcase
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [PHASES];
		logic [31:0]      k;
		int               p;
		int               n;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		cfg_valid = 1'b0;
		cfg_data = CAP_RESET;
		err_count = 0;
		n_gets = 0;
		n_hits = 0;
		n_puts = 0;
		n_cfg = 0;
		gap_left = 0;
		gap_odds = 3;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes of key and value, update in place, misses
		pend_q.push_back(mk_cmd(OP_GET, 32'h0000_0000, 32'h0));
		pend_q.push_back(mk_cmd(OP_PUT, 32'h7fff_ffff, 32'h8000_0000));
		pend_q.push_back(mk_cmd(OP_PUT, 32'h8000_0000, 32'h7fff_ffff));
		pend_q.push_back(mk_cmd(OP_PUT, 32'h0000_0000, 32'h0000_0000));
		pend_q.push_back(mk_cmd(OP_PUT, 32'hffff_ffff, 32'hffff_ffff));
		pend_q.push_back(mk_cmd(OP_GET, 32'h7fff_ffff, 32'h1234_5678));
		pend_q.push_back(mk_cmd(OP_GET, 32'h8000_0000, 32'h0));
		pend_q.push_back(mk_cmd(OP_PUT, 32'h7fff_ffff, 32'h5555_5555));
		pend_q.push_back(mk_cmd(OP_GET, 32'h7fff_ffff, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'h1234_5678, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'hffff_ffff, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'h0000_0000, 32'h0));

		// capacity dropped below occupancy, then capacity zero
		write_capacity(5'd2);
		pend_q.push_back(mk_cmd(OP_PUT, 32'h0bad_f00d, 32'haaaa_aaaa));
		pend_q.push_back(mk_cmd(OP_GET, 32'h0000_0000, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'hffff_ffff, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'h7fff_ffff, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'h0bad_f00d, 32'h0));
		write_capacity(5'd0);
		pend_q.push_back(mk_cmd(OP_PUT, 32'h0000_0005, 32'h0000_0006));
		pend_q.push_back(mk_cmd(OP_GET, 32'h0000_0005, 32'h0));
		pend_q.push_back(mk_cmd(OP_GET, 32'h0bad_f00d, 32'h0));

		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd0, 5'd0, 5'd16};
		caps[5] = CAP_W'($urandom_range(0, 31));
		caps[6] = CAP_W'($urandom_range(2, 15));
		for (p = 0; p < PHASES; p++) begin
			write_capacity(caps[p]);
			case ($urandom_range(0, 3))
				0:       gap_odds = 0;
				1:       gap_odds = 2;
				2:       gap_odds = 4;
				default: gap_odds = 8;
			endcase
			if (p == PHASES - 1) begin
				gap_odds = 0;
				gap_left = 0;
			end
			fill_pool();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0)
					k = $urandom;
				else
					k = key_pool[$urandom_range(0, pool_n - 1)];
				pend_q.push_back(mk_cmd($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom));
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (expected_reads.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_reads.size()));
		$display("covered %0d gets (%0d hits) and %0d puts", n_gets, n_hits, n_puts);
		$display("across %0d capacity writes incl. 0, 1, 16 and saturating values", n_cfg);
		if (err_count == 0) begin
			$display("lru_key_value_cache regression: pass");
		end else begin
			$display("lru_key_value_cache regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/lkvc_pkg.sv
sv/lkvc_match.sv
sv/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
